@@ sv/irt_pkg.sv @@
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and constants for the input remap table: operation codes,
// controller states, table word layout and the scan control/status structs.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int unsigned DevW  = 8;
  localparam int unsigned IdW   = 32;
  localparam int unsigned PairW = DevW + IdW;
  // table word: {valid, key pair, target pair}
  localparam int unsigned WordW = 1 + 2 * PairW;

  localparam int unsigned WordValidBit = WordW - 1;
  localparam int unsigned WordKeyLsb   = PairW;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_SET    = 2'd1,
    MODE_UNSET  = 2'd2,
    MODE_CLEAR  = 2'd3
  } irt_mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CLEAR,
    ST_COMMIT
  } irt_state_e;

  typedef struct packed {
    logic clr;  // start of a new operation, drop previous results
    logic vld;  // read word of this cycle belongs to the scan
  } irt_scan_ctl_t;

  typedef struct packed {
    logic hit;   // a valid entry holds the key
    logic free;  // a free slot was seen
  } irt_scan_sts_t;

endpackage

@@ sv/input_remap_table_unit.sv @@
// Lookup, set and unset walk the table in the scan and drain steps and raise
// the result word from the commit step; clear zeroes the table in the clear
// step, then commits. The single table read port walks every entry once per
// operation, so no input word is taken until the previous one has committed;
// a stalled result word holds the commit step. After reset a clearing pass
// writes every table word to zero; no input word is taken until it finishes.
// ----------------------------------------------------------------------------
// input_remap_table_unit
// Remap table for (device, id) pairs: lookup, set, unset and clear over a
// table held in one synchronous memory, searched by a sequential scan.
// ----------------------------------------------------------------------------
module input_remap_table_unit import irt_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      mode_i,
  input  logic [DevW-1:0] key_dev_i,
  input  logic [IdW-1:0]  key_id_i,
  input  logic [DevW-1:0] new_dev_i,
  input  logic [IdW-1:0]  new_id_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [DevW-1:0] out_dev_o,
  output logic [IdW-1:0]  out_id_o,
  output logic            hit_o,
  output logic            status_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(ENTRIES - 1);

  irt_state_e    state_q, state_d;
  logic [AW-1:0] scan_q, scan_d;
  logic          rd_pend_q;
  logic [AW-1:0] rd_idx_q;
  irt_mode_e     mode_q;
  logic [PairW-1:0] key_q, new_q;

  logic             out_valid_q, out_valid_d;
  logic [PairW-1:0] out_pair_q, out_pair_d;
  logic             out_hit_q, out_hit_d;
  logic             out_status_q, out_status_d;

  logic             accept;
  logic             out_free;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [WordW-1:0] wdata;
  logic [WordW-1:0] rd_word;

  irt_scan_ctl_t    scan_ctl;
  irt_scan_sts_t    scan_sts;
  logic [AW-1:0]    hit_idx;
  logic [AW-1:0]    free_idx;
  logic [PairW-1:0] tgt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign scan_ctl.clr = accept;
  assign scan_ctl.vld = rd_pend_q;

  irt_ram #(
    .WIDTH (WordW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (scan_q),
    .rdata_o (rd_word)
  );

  irt_match #(
    .ENTRIES (ENTRIES)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .rd_idx_i   (rd_idx_q),
    .rd_word_i  (rd_word),
    .key_i      (key_q),
    .sts_o      (scan_sts),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .tgt_o      (tgt)
  );

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    we           = 1'b0;
    waddr        = scan_q;
    wdata        = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_pair_d   = out_pair_q;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        // zero word drops the valid bit
        we = 1'b1;
        if (scan_q == LastIdx) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_COMMIT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scan_d  = '0;
          state_d = (irt_mode_e'(mode_i) == MODE_CLEAR) ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_pair_d   = key_q;
          out_hit_d    = 1'b0;
          out_status_d = 1'b0;
          unique case (mode_q)
            MODE_LOOKUP: begin
              out_hit_d = scan_sts.hit;
              if (scan_sts.hit) begin
                out_pair_d = tgt;
              end
            end
            MODE_SET: begin
              out_hit_d = scan_sts.hit;
              wdata     = {1'b1, key_q, new_q};
              if (scan_sts.hit) begin
                we    = 1'b1;
                waddr = hit_idx;
              end else if (scan_sts.free) begin
                we    = 1'b1;
                waddr = free_idx;
              end else begin
                out_status_d = 1'b1;
              end
            end
            MODE_UNSET: begin
              out_hit_d = scan_sts.hit;
              we        = scan_sts.hit;
              waddr     = hit_idx;
              wdata     = {1'b0, key_q, new_q};
            end
            MODE_CLEAR: begin
              out_hit_d = 1'b0;
            end
            default: begin
              out_hit_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      rd_pend_q   <= (state_q == ST_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= scan_q;
    out_pair_q   <= out_pair_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
    if (accept) begin
      mode_q <= irt_mode_e'(mode_i);
      key_q  <= {key_dev_i, key_id_i};
      new_q  <= {new_dev_i, new_id_i};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dev_o   = out_pair_q[PairW-1:IdW];
  assign out_id_o    = out_pair_q[IdW-1:0];
  assign hit_o       = out_hit_q;
  assign status_o    = out_status_q;

`ifndef SYNTH
  // a new result word only comes out of the commit step
  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_COMMIT)
    else $error("result word raised outside commit");

  // the table is never written while it is being searched or while idle
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_DRAIN || state_q == ST_IDLE) |-> !we)
    else $error("table write during scan or idle");

  // a dropped set never reports a hit
  a_status_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && status_o))
    else $error("hit and full status both set");

  // a set into a full table leaves the table untouched
  a_full_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && mode_q == MODE_SET && !scan_sts.hit && !scan_sts.free)
      |-> !we)
    else $error("write on full table");
`endif

endmodule

@@ sv/irt_ram.sv @@
// ----------------------------------------------------------------------------
// irt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module irt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/irt_match.sv @@
// ----------------------------------------------------------------------------
// irt_match
// Scan evaluator: compares each word read from the table against the key,
// keeps the matching slot and its target, and the lowest free slot.
// ----------------------------------------------------------------------------
module irt_match import irt_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  irt_scan_ctl_t                                 ctl_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx_i,
  input  logic [WordW-1:0]                              rd_word_i,
  input  logic [PairW-1:0]                              key_i,
  output irt_scan_sts_t                                 sts_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_idx_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_idx_o,
  output logic [PairW-1:0]                              tgt_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          hit_q, hit_d;
  logic          free_q, free_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic [PairW-1:0] tgt_q, tgt_d;
  logic          word_valid;
  logic          key_eq;

  assign word_valid = rd_word_i[WordValidBit];
  assign key_eq     = (rd_word_i[WordKeyLsb +: PairW] == key_i);

  always_comb begin
    hit_d      = hit_q;
    free_d     = free_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    tgt_d      = tgt_q;
    if (ctl_i.clr) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (ctl_i.vld) begin
      if (word_valid && key_eq) begin
        hit_d     = 1'b1;
        hit_idx_d = rd_idx_i;
        tgt_d     = rd_word_i[PairW-1:0];
      end else if (!word_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    tgt_q      <= tgt_d;
  end

  assign sts_o.hit  = hit_q;
  assign sts_o.free = free_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign tgt_o      = tgt_q;

endmodule
